FILE: design/ring_buffer_deque_assert.svh
// ----------------------------------------------------------------------------
// Ring buffer deque assertion macros
// Shared property wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RING_BUFFER_DEQUE_ASSERT_SVH
`define RING_BUFFER_DEQUE_ASSERT_SVH

// Same-cycle implication
`define RBD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RBD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Opcodes, default sizes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package rbd_pkg;

  // Port widths fixed by the item format
  localparam int DATA_W       = 32;
  localparam int OPCODE_W     = 2;

  // Defaults for the top-level parameters
  localparam int DEF_DEPTH     = 64;
  localparam int DEF_WORD_BITS = 32;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_REAR  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_REAR   = 2'd3;

  // Controller -> datapath commands
  typedef struct packed {
    logic step;      // accepted item that changes state
    logic push;      // accepted item is a push
    logic front;     // accepted item works on the front end
    logic ok;        // accepted item succeeds
    logic load_now;  // result of a push or refused item loads this edge
    logic load_pop;  // result of a pop loads from read data this edge
  } rbd_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic full;
    logic empty;
  } rbd_status_t;

endpackage

`default_nettype wire

FILE: design/rbd_ram.sv
// ----------------------------------------------------------------------------
// rbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/rbd_ctrl.sv
// ----------------------------------------------------------------------------
// rbd_ctrl
// Handshake and sequencing: decodes each item, waits out the RAM read of a
// pop and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ring_buffer_deque_assert.svh"

module rbd_ctrl
  import rbd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [OPCODE_W-1:0] in_opcode,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire rbd_status_t         status,
  output rbd_cmd_t                 cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RD   = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free, accept, is_push, is_front, item_ok;

  // Result register can take a new item
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  // Opcode decode
  assign is_push  = (in_opcode == OP_PUSH_FRONT) || (in_opcode == OP_PUSH_REAR);
  assign is_front = (in_opcode == OP_PUSH_FRONT) || (in_opcode == OP_POP_FRONT);
  assign item_ok  = is_push ? !status.full : !status.empty;

  // Commands
  always_comb begin
    cmd.step     = accept && item_ok;
    cmd.push     = is_push;
    cmd.front    = is_front;
    cmd.ok       = item_ok;
    cmd.load_now = accept && (is_push || !item_ok);
    cmd.load_pop = (state_r == S_RD) && out_free;
  end

  // Sequencer: a successful pop waits in S_RD until its read data can load
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && !is_push && item_ok) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid
  always_comb begin
    if (cmd.load_now || cmd.load_pop) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `RBD_ASSERT_NXT(a_pop_waits_read, cmd.step && !cmd.push, state_r == S_RD,
                  "successful pop did not enter read wait")
  `RBD_ASSERT_IMP(a_full_empty_excl, 1'b1, !(status.full && status.empty),
                  "queue reported full and empty at once")
  `RBD_ASSERT_NXT(a_pop_result_valid, cmd.load_pop, out_valid_r,
                  "pop result loaded but not presented")

endmodule

`default_nettype wire

FILE: design/rbd_dpath.sv
// ----------------------------------------------------------------------------
// rbd_dpath
// End indices, fill count, storage RAM and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ring_buffer_deque_assert.svh"

module rbd_dpath
  import rbd_pkg::*;
#(
  parameter int DEPTH     = DEF_DEPTH,
  parameter int WORD_BITS = DEF_WORD_BITS,
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int FILL_W   = $clog2(DEPTH + 1),
  localparam int KEEP_W   = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rbd_cmd_t          cmd,
  output rbd_status_t            status,
  input  wire logic [DATA_W-1:0] in_data_in,
  output logic                   out_ok,
  output logic [DATA_W-1:0]      out_data_out,
  output logic [FILL_W-1:0]      out_fill_level
);

  localparam logic [AW-1:0]     LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_CNT  = FILL_W'(DEPTH);

  logic [AW-1:0]     front_r, front_nxt;
  logic [AW-1:0]     rear_r, rear_nxt;
  logic [FILL_W-1:0] occ_r, occ_nxt;
  logic [AW-1:0]     front_up, front_dn, rear_up, rear_dn;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [KEEP_W-1:0] ram_rdata;
  logic [DATA_W-1:0] rd_ext;
  logic              ok_r, ok_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  assign status.full  = (occ_r == FULL_CNT);
  assign status.empty = (occ_r == '0);

  // Wrapping neighbors of both ends
  assign front_up = (front_r == LAST_SLOT) ? '0 : front_r + 1'b1;
  assign front_dn = (front_r == '0) ? LAST_SLOT : front_r - 1'b1;
  assign rear_up  = (rear_r == LAST_SLOT) ? '0 : rear_r + 1'b1;
  assign rear_dn  = (rear_r == '0) ? LAST_SLOT : rear_r - 1'b1;

  // Index and count update
  always_comb begin
    front_nxt = front_r;
    rear_nxt  = rear_r;
    occ_nxt   = occ_r;
    if (cmd.step) begin
      if (cmd.push) begin
        occ_nxt = occ_r + 1'b1;
        if (cmd.front) begin
          front_nxt = front_up;
        end else begin
          rear_nxt = rear_dn;
        end
      end else begin
        occ_nxt = occ_r - 1'b1;
        if (cmd.front) begin
          front_nxt = front_dn;
        end else begin
          rear_nxt = rear_up;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      rear_r  <= LAST_SLOT;
      occ_r   <= '0;
    end else begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      occ_r   <= occ_nxt;
    end
  end

  // Storage: a push writes at the free slot, a pop reads the slot it frees
  assign ram_we    = cmd.step && cmd.push;
  assign ram_waddr = cmd.front ? front_r : rear_r;
  assign ram_re    = cmd.step && !cmd.push;
  assign ram_raddr = cmd.front ? front_dn : rear_up;

  rbd_ram #(
    .WIDTH (KEEP_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data_in[KEEP_W-1:0]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Zero-extend the stored word to the port width
  always_comb begin
    rd_ext = '0;
    rd_ext[KEEP_W-1:0] = ram_rdata;
  end

  // Result register
  always_comb begin
    ok_nxt   = ok_r;
    data_nxt = data_r;
    fill_nxt = fill_r;
    if (cmd.load_now) begin
      ok_nxt   = cmd.ok;
      data_nxt = '0;
      fill_nxt = occ_nxt;
    end else if (cmd.load_pop) begin
      ok_nxt   = 1'b1;
      data_nxt = rd_ext;
      fill_nxt = occ_r;
    end
  end

  always_ff @(posedge clk) begin
    ok_r   <= ok_nxt;
    data_r <= data_nxt;
    fill_r <= fill_nxt;
  end

  assign out_ok         = ok_r;
  assign out_data_out   = data_r;
  assign out_fill_level = fill_r;

  `RBD_ASSERT_IMP(a_occ_bound, 1'b1, occ_r <= FULL_CNT,
                  "fill count above depth")

endmodule

`default_nettype wire

FILE: design/ring_buffer_deque.sv
// Results: a push or a refused item gives its result in the cycle after accept;
// a successful pop gives it through its registered RAM read and the result register.
// Throughput: one item per cycle for pushes and refused items while results are
// not stalled; a pop holds off the next item until its RAM read data loads.
// Reset: rst_n synchronous, active low; clears indices, fill count and valid.
// Storage is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Double-ended queue of DEPTH words in a ring buffer, push and pop at both
// ends, one result item per input item.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_buffer_deque
  import rbd_pkg::*;
#(
  parameter int DEPTH     = DEF_DEPTH,
  parameter int WORD_BITS = DEF_WORD_BITS,
  localparam int FILL_W   = $clog2(DEPTH + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [OPCODE_W-1:0] in_opcode,
  input  wire logic [DATA_W-1:0]   in_data_in,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_ok,
  output logic [DATA_W-1:0]        out_data_out,
  output logic [FILL_W-1:0]        out_fill_level
);

  rbd_cmd_t    cmd;
  rbd_status_t status;

  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rbd_dpath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_data_in     (in_data_in),
    .out_ok         (out_ok),
    .out_data_out   (out_data_out),
    .out_fill_level (out_fill_level)
  );

endmodule

`default_nettype wire

FILE: sim/ring_buffer_deque_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_deque_check
// Watches both channels of the deque. Every accepted item runs through a
// local deque model and queues its result; every accepted result is compared
// field by field with the oldest queued one. Mismatches are counted.
// ----------------------------------------------------------------------------

module ring_buffer_deque_check
  import rbd_pkg::*;
#(
  parameter int DEPTH     = DEF_DEPTH,
  parameter int WORD_BITS = DEF_WORD_BITS,
  localparam int FILL_W   = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [DATA_W-1:0]   in_data_in,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                out_ok,
  input  logic [DATA_W-1:0]   out_data_out,
  input  logic [FILL_W-1:0]   out_fill_level,
  output int                  fail_count,
  output int                  pending
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [DATA_W-1:0] WORD_MASK = {DATA_W{1'b1}} >> (DATA_W - WORD_BITS);

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] word;
    logic [FILL_W-1:0] fill;
  } deque_result_t;

  // Local copy of the deque state
  logic [DATA_W-1:0] slot_words [DEPTH];
  logic [IDX_W-1:0]  front_idx;
  logic [IDX_W-1:0]  rear_idx;
  int                stored;

  deque_result_t     results_due [$];
  int                mismatches;

  initial begin
    fail_count = 0;
    pending    = 0;
    mismatches = 0;
  end

  function automatic logic [IDX_W-1:0] slot_above(input logic [IDX_W-1:0] s);
    return (s == IDX_W'(DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] slot_below(input logic [IDX_W-1:0] s);
    return (s == '0) ? IDX_W'(DEPTH - 1) : s - 1'b1;
  endfunction

  // Apply one operation to the local deque and return its result
  task automatic deque_apply(input logic [OPCODE_W-1:0] op,
                             input logic [DATA_W-1:0] word,
                             output deque_result_t res);
    res = '0;
    if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
      if (stored < DEPTH) begin
        if (op == OP_PUSH_FRONT) begin
          slot_words[front_idx] = word & WORD_MASK;
          front_idx = slot_above(front_idx);
        end else begin
          slot_words[rear_idx] = word & WORD_MASK;
          rear_idx = slot_below(rear_idx);
        end
        stored++;
        res.ok = 1'b1;
      end
    end else if (stored > 0) begin
      if (op == OP_POP_FRONT) begin
        front_idx = slot_below(front_idx);
        res.word  = slot_words[front_idx];
      end else begin
        rear_idx = slot_above(rear_idx);
        res.word = slot_words[rear_idx];
      end
      stored--;
      res.ok = 1'b1;
    end
    res.fill = FILL_W'(stored);
  endtask

  // Compare results first, then queue the expectation of a new item
  always @(posedge clk) begin
    deque_result_t want;
    deque_result_t got;
    if (!rst_n) begin
      front_idx = '0;
      rear_idx  = IDX_W'(DEPTH - 1);
      stored    = 0;
      results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{ok: out_ok, word: out_data_out, fill: out_fill_level};
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result ok=%0b data=%h fill=%0d",
                   $time, got.ok, got.word, got.fill);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (got.ok !== want.ok) begin
            $display("%0t: ok expected %0b actual %0b", $time, want.ok, got.ok);
            mismatches++;
          end
          if (got.word !== want.word) begin
            $display("%0t: data_out expected %h actual %h", $time, want.word, got.word);
            mismatches++;
          end
          if (got.fill !== want.fill) begin
            $display("%0t: fill_level expected %0d actual %0d",
                     $time, want.fill, got.fill);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        deque_apply(in_opcode, in_data_in, want);
        results_due.push_back(want);
      end
    end
    fail_count <= mismatches;
    pending    <= results_due.size();
  end

endmodule

FILE: sim/ring_buffer_deque_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_deque_test
// Drives the deque with a short directed sequence (empty pops, extreme words,
// wrap of the front end) and then random phases biased toward filling,
// draining or mixing, so that full and empty are hit many times. Both channels
// idle at random outside a quiet stretch. The checker and a watchdog decide pass or fail.
// ----------------------------------------------------------------------------

module ring_buffer_deque_test;
  import rbd_pkg::*;

  localparam int DEPTH        = DEF_DEPTH;
  localparam int WORD_BITS    = DEF_WORD_BITS;
  localparam int FILL_W       = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 1450;
  localparam int IDLE_PCT     = 17;
  localparam int QUIET_LIMIT  = 2000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OPCODE_W-1:0] in_opcode = OP_PUSH_FRONT;
  logic [DATA_W-1:0]   in_data_in = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_ok;
  logic [DATA_W-1:0]   out_data_out;
  logic [FILL_W-1:0]   out_fill_level;

  logic                calm = 1'b0;
  int                  fail_count;
  int                  pending;
  int                  quiet_cycles = 0;

  ring_buffer_deque #(.DEPTH(DEPTH), .WORD_BITS(WORD_BITS)) i_dut (.*);

  ring_buffer_deque_check #(.DEPTH(DEPTH), .WORD_BITS(WORD_BITS)) i_check (.*);

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Random back-pressure on results
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Watchdog: too long without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Present one item after an optional gap and hold it until accepted
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [DATA_W-1:0] word);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_data_in <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // push_pct sets the bias toward pushes
  function automatic logic [OPCODE_W-1:0] pick_op(input int push_pct);
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
    end
    return $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
  endfunction

  initial begin
    int sent;
    int phase_len;
    int push_pct;
    sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty pops, extreme words, wrap of the front end past slot zero
    send_item(OP_POP_FRONT, 32'hFFFF_FFFF);
    send_item(OP_POP_REAR, 32'h0000_0000);
    send_item(OP_PUSH_FRONT, 32'h0000_0000);
    send_item(OP_PUSH_REAR, 32'hFFFF_FFFF);
    send_item(OP_PUSH_FRONT, 32'hAAAA_AAAA);
    send_item(OP_PUSH_REAR, 32'h5555_5555);
    send_item(OP_POP_REAR, 32'h1234_5678);
    send_item(OP_POP_FRONT, 32'hFFFF_FFFF);
    send_item(OP_POP_FRONT, 32'h0000_0000);
    send_item(OP_POP_FRONT, 32'h0000_0000);
    send_item(OP_POP_REAR, 32'hFFFF_FFFF);
    send_item(OP_PUSH_REAR, 32'h8000_0000);
    send_item(OP_POP_FRONT, 32'h0000_0000);
    send_item(OP_PUSH_FRONT, 32'h0000_0001);
    send_item(OP_POP_REAR, 32'hFFFF_FFFF);
    send_item(OP_POP_FRONT, 32'h0000_0000);

    // Random phases: fill toward full, drain toward empty, or mix
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(40, 200);
      // Last phase stops at the item budget
      if (phase_len > RANDOM_ITEMS - sent) begin
        phase_len = RANDOM_ITEMS - sent;
      end
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      repeat (phase_len) begin
        calm <= (sent >= 600 && sent < 850);
        send_item(pick_op(push_pct), $urandom());
        sent++;
      end
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    // Drain outstanding results, then settle before reading the fail count
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
